// ----- design/frustum_cull_test_defines.svh -----
// Assertion macros used by the plane test of the culling pipeline
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle
`define FCT_ASSERT_IMP(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle
`define FCT_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/fct_pkg.sv -----
package fct_pkg;

    localparam int PlaneCount  = 6;
    localparam int CornerCount = 8;

    // Corner coordinate, Q.14
    localparam int CornerW = 34;
    // Plane sum, Q.28
    localparam int SumW    = 54;

    typedef enum logic [1:0] {
        CMD_POINT = 2'd0,
        CMD_AABB  = 2'd1,
        CMD_OBB   = 2'd2,
        CMD_RSVD  = 2'd3
    } t_cmd;

    typedef logic signed [CornerW-1:0] t_corner [3];
    typedef logic [63:0] t_plane;

    // Signed 16-bit lane of a packed word
    function automatic logic signed [15:0] lane16(input logic [63:0] w, input int k);
        lane16 = w[16*k +: 16];
    endfunction

endpackage

// ----- design/frustum_cull_test.sv -----
// Six-plane frustum cull. One item is taken per clock whenever start is high
// (busy stays low). o_outside is valid with o_done after three corner-building
// stages and three plane-test stages. Results are strobed for one cycle and
// cannot be held off. Plane registers are written through
// i_cfg_we/i_cfg_index/i_cfg_data; the user must write them only while the
// pipeline is empty, and the block itself does not enforce it.
module frustum_cull_test (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic [1:0]  i_command,
    input  logic [47:0] i_base_vector,
    input  logic [47:0] i_far_corner,
    input  logic [47:0] i_axis_one,
    input  logic [47:0] i_axis_two,
    input  logic [47:0] i_axis_three,
    input  logic [47:0] i_half_sizes,
    output logic        o_done,
    output logic        o_outside
);
    import fct_pkg::*;

    logic [63:0] r_plane [6];
    logic        cg_valid;
    t_cmd        cg_cmd;
    logic signed [CornerW-1:0] cg_corner [8][3];

    // plane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_plane[i] <= 64'd0;
        end else if (i_cfg_we && i_cfg_index < 3'd6) begin
            r_plane[i_cfg_index] <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    fct_corner_gen u_cg (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(start && !busy),
        .i_command(t_cmd'(i_command)), .i_base_vector(i_base_vector),
        .i_far_corner(i_far_corner), .i_axis_one(i_axis_one),
        .i_axis_two(i_axis_two), .i_axis_three(i_axis_three),
        .i_half_sizes(i_half_sizes), .o_valid(cg_valid),
        .o_command(cg_cmd), .o_corner(cg_corner)
    );

    fct_plane_eval u_pe (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(cg_valid),
        .i_command(cg_cmd), .i_corner(cg_corner), .i_plane(r_plane),
        .o_strobe(o_done), .o_outside(o_outside)
    );

endmodule

// ----- design/fct_corner_gen.sv -----
// Corner generation: three stages (products, axis sums, corner assembly)
module fct_corner_gen (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  fct_pkg::t_cmd           i_command,
    input  logic [47:0]             i_base_vector,
    input  logic [47:0]             i_far_corner,
    input  logic [47:0]             i_axis_one,
    input  logic [47:0]             i_axis_two,
    input  logic [47:0]             i_axis_three,
    input  logic [47:0]             i_half_sizes,
    output logic                    o_valid,
    output fct_pkg::t_cmd           o_command,
    output logic signed [fct_pkg::CornerW-1:0] o_corner [8][3]
);
    import fct_pkg::*;

    // stage 1: axis * half products
    logic          r_v1;
    t_cmd          r_cmd1;
    logic [47:0]   r_base1, r_far1;
    logic signed [31:0] r_prod1 [3][3];
    logic [47:0]   axes [3];

    assign axes[0] = i_axis_one;
    assign axes[1] = i_axis_two;
    assign axes[2] = i_axis_three;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_cmd1  <= i_command;
        r_base1 <= i_base_vector;
        r_far1  <= i_far_corner;
        for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
                r_prod1[a][k] <= lane16({16'd0, axes[a]}, k) *
                                 lane16({16'd0, i_half_sizes}, a);
            end
        end
    end

    // stage 2: center plus/minus axis one, keep axes two and three
    logic          r_v2;
    t_cmd          r_cmd2;
    logic [47:0]   r_far2;
    logic signed [CornerW-1:0] r_c2 [2][3];
    logic signed [31:0] r_p2 [2][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_cmd2 <= r_cmd1;
        r_far2 <= r_far1;
        for (int k = 0; k < 3; k++) begin
            r_c2[0][k] <= CornerW'(signed'(lane16({16'd0, r_base1}, k))) * 16384
                          + CornerW'(r_prod1[0][k]);
            r_c2[1][k] <= CornerW'(signed'(lane16({16'd0, r_base1}, k))) * 16384
                          - CornerW'(r_prod1[0][k]);
            r_p2[0][k] <= r_prod1[1][k];
            r_p2[1][k] <= r_prod1[2][k];
        end
    end

    // base lanes for point and box minimum travel alongside
    logic [47:0] r_base2;
    always_ff @(posedge i_clk) begin
        r_base2 <= r_base1;
    end

    // stage 3: assemble eight corners
    logic          r_v3;
    t_cmd          r_cmd3;
    logic signed [CornerW-1:0] r_c3 [8][3];
    logic signed [CornerW-1:0] n_c3 [8][3];

    always_comb begin
        for (int j = 0; j < 8; j++) begin
            for (int k = 0; k < 3; k++) begin
                if (r_cmd2 == CMD_AABB) begin
                    // corner bit k picks the far corner lane
                    n_c3[j][k] = CornerW'(signed'(lane16({16'd0,
                        (j[k] ? r_far2 : r_base2)}, k))) * 16384;
                end else if (r_cmd2 == CMD_POINT) begin
                    // point mode: the point itself, axes ignored
                    n_c3[j][k] = CornerW'(signed'(lane16({16'd0, r_base2}, k))) * 16384;
                end else begin
                    n_c3[j][k] = r_c2[j[2]][k]
                        + (j[1] ? -CornerW'(r_p2[0][k]) : CornerW'(r_p2[0][k]))
                        + (j[0] ? -CornerW'(r_p2[1][k]) : CornerW'(r_p2[1][k]));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_cmd3 <= r_cmd2;
        for (int j = 0; j < 8; j++) begin
            for (int k = 0; k < 3; k++) begin
                r_c3[j][k] <= n_c3[j][k];
            end
        end
    end

    assign o_valid   = r_v3;
    assign o_command = r_cmd3;
    assign o_corner  = r_c3;

endmodule

// ----- design/fct_plane_eval.sv -----
// Plane test: products, sums, then per-plane reduction
module fct_plane_eval (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  fct_pkg::t_cmd i_command,
    input  logic signed [fct_pkg::CornerW-1:0] i_corner [8][3],
    input  logic [63:0]   i_plane [6],
    output logic          o_strobe,
    output logic          o_outside
);
    import fct_pkg::*;

    // stage A: normal * coordinate products
    logic  r_va;
    t_cmd  r_cmda;
    logic signed [49:0] r_pr [6][8][3];
    logic signed [SumW-1:0] r_off [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else begin
            r_va <= i_valid;
        end
        r_cmda <= i_command;
        for (int i = 0; i < 6; i++) begin
            r_off[i] <= SumW'(signed'(lane16(i_plane[i], 3))) <<< 28;
            for (int j = 0; j < 8; j++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pr[i][j][k] <= lane16(i_plane[i], k) * i_corner[j][k];
                end
            end
        end
    end

    // stage B: sign of each plane sum
    logic r_vb;
    t_cmd r_cmdb;
    logic r_bh [6][8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va;
        end
        r_cmdb <= r_cmda;
        for (int i = 0; i < 6; i++) begin
            for (int j = 0; j < 8; j++) begin
                r_bh[i][j] <= (r_off[i] + SumW'(r_pr[i][j][0]) + SumW'(r_pr[i][j][1])
                               + SumW'(r_pr[i][j][2])) < 0;
            end
        end
    end

    // stage C: reduce to one bit
    logic r_vc, r_out;
    logic n_out;

    always_comb begin
        n_out = 1'b0;
        for (int i = 0; i < 6; i++) begin
            case (r_cmdb)
                CMD_POINT: n_out = n_out | r_bh[i][0];
                CMD_AABB, CMD_OBB: n_out = n_out | (r_bh[i][0] & r_bh[i][1] & r_bh[i][2]
                    & r_bh[i][3] & r_bh[i][4] & r_bh[i][5] & r_bh[i][6] & r_bh[i][7]);
                default: n_out = n_out;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc  <= 1'b0;
            r_out <= 1'b0;
        end else begin
            r_vc  <= r_vb;
            r_out <= n_out & r_vb;
        end
    end

    assign o_strobe  = r_vc;
    assign o_outside = r_out;

`include "frustum_cull_test_defines.svh"
    `FCT_ASSERT_IMP(a_out_only_valid, i_clk, i_rst_n, !r_vc, !r_out)
    `FCT_ASSERT_NEXT(a_valid_flow, i_clk, i_rst_n, r_va, r_vb)
    `FCT_ASSERT_NEXT(a_rsvd_inside, i_clk, i_rst_n, r_vb && r_cmdb == CMD_RSVD, !r_out)

endmodule
